// File: hw/rtl/cpts_pkg.sv
// cpts_pkg: shared types and codes of the counter priority task scheduler
// no dependencies; used by all scheduler modules and the testbench
package cpts_pkg;

    // operation codes of the request word
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_YIELD = 3'd1;
    localparam logic [2:0] OP_EXIT  = 3'd2;
    localparam logic [2:0] OP_PDIS  = 3'd3;
    localparam logic [2:0] OP_PEN   = 3'd4;
    localparam logic [2:0] OP_LOAD  = 3'd5;

    localparam logic signed [15:0] CNT_MIN = 16'sh8000;
    localparam logic [7:0]         PREEMPT_MAX = 8'hff;

    typedef enum logic [1:0] {
        ST_RUNNABLE = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_ZOMBIE   = 2'd2
    } task_st_t;

    // one task table entry
    typedef struct packed {
        logic                present;
        task_st_t            st;
        logic signed [15:0]  counter;
        logic [7:0]          prio;
        logic [7:0]          preempt;
    } entry_t;

    // result word
    typedef struct packed {
        logic [1:0] out_cpu;
        logic       rescheduled;
        logic [5:0] current_task;
        logic [5:0] previous_task;
        logic       recalculated;
        logic       status;
    } res_t;

endpackage

// File: hw/rtl/cpts_if.sv
// cpts_if: valid/ready channels for request and result words
// depends on nothing; field widths are those of the request and result words
interface cpts_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [1:0]  cpu;
    logic [5:0]  slot;
    logic [7:0]  new_priority;
    logic [14:0] new_counter;

    modport source (output valid, opcode, cpu, slot, new_priority, new_counter,
                    input ready);
    modport sink (input valid, opcode, cpu, slot, new_priority, new_counter,
                  output ready);
endinterface

interface cpts_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_cpu;
    logic       rescheduled;
    logic [5:0] current_task;
    logic [5:0] previous_task;
    logic       recalculated;
    logic       status;

    modport source (output valid, out_cpu, rescheduled, current_task, previous_task,
                    recalculated, status, input ready);
    modport sink (input valid, out_cpu, rescheduled, current_task, previous_task,
                  recalculated, status, output ready);
endinterface

// File: hw/rtl/cpts_mem.sv
// cpts_mem: task table, one write and one registered read port
// depends on cpts_pkg for the entry type
module cpts_mem #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  cpts_pkg::entry_t    wdata,
    input  logic [AW-1:0]       raddr,
    output cpts_pkg::entry_t    rdata
);
    import cpts_pkg::*;

    entry_t mem [DEPTH];

    // write, and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/cpts_ctrl.sv
// cpts_ctrl: operation sequencer, table sweeps and per-cpu current slots
// depends on cpts_pkg and cpts_in_if; drives the task table in cpts_mem
module cpts_ctrl #(
    parameter int TASK_SLOTS = 64,
    parameter int CPU_COUNT = 4,
    localparam int AW = $clog2(TASK_SLOTS)
) (
    input  logic              clk,
    input  logic              rst_n,
    cpts_in_if.sink           req,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output cpts_pkg::entry_t  mem_wdata,
    output logic [AW-1:0]     mem_raddr,
    input  cpts_pkg::entry_t  mem_rdata,
    output logic              res_valid,
    output cpts_pkg::res_t    res,
    input  logic              res_take
);
    import cpts_pkg::*;

    localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int IW = AW + 1;
    localparam int PW = $clog2(TASK_SLOTS + 1);

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_RMW      = 9'b000000100,
        S_SCAN     = 9'b000001000,
        S_RECALC   = 9'b000010000,
        S_PICK     = 9'b000100000,
        S_PICK_CHK = 9'b001000000,
        S_PREV     = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [2:0]             op_reg, op_next;
    logic [1:0]             cpu_raw_reg, cpu_raw_next;
    logic                   bad_cpu_reg, bad_cpu_next;
    logic [AW-1:0]          slot_reg, slot_next;
    logic [7:0]             prio_reg, prio_next;
    logic [14:0]            ncnt_reg, ncnt_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic                   v_reg, v_next;
    logic [AW-1:0]          aq_reg, aq_next;
    logic                   found_reg, found_next;
    logic signed [15:0]     best_reg, best_next;
    logic [AW-1:0]          pick_reg, pick_next;
    logic [PW-1:0]          pass_reg, pass_next;
    logic                   recalc_reg, recalc_next;
    logic                   resched_reg, resched_next;
    logic                   status_reg, status_next;
    logic [AW-1:0]          prev_reg, prev_next;
    logic [AW-1:0]          cur_reg [CPU_COUNT];
    logic [AW-1:0]          cur_next [CPU_COUNT];

    logic                   rd_en;
    logic [CW-1:0]          cpu_idx;
    logic [CW-1:0]          in_cpu_idx;
    logic [AW-1:0]          cur_sel;
    logic [AW-1:0]          in_slot;
    logic                   slot_cur;
    logic signed [15:0]     dec;
    logic signed [15:0]     recalc_val;
    entry_t                 e;

    assign cpu_idx    = CW'(cpu_raw_reg);
    assign in_cpu_idx = CW'(req.cpu);
    assign cur_sel    = cur_reg[cpu_idx];
    assign in_slot    = AW'(req.slot);
    assign e          = mem_rdata;
    assign req.ready  = (state_reg == S_IDLE);

    // saturating decrement and halving recompute of the entry just read
    assign dec = (e.counter == CNT_MIN) ? e.counter : e.counter - 16'sd1;
    assign recalc_val = (e.counter >>> 1) + $signed({8'd0, e.prio});

    // is the slot being loaded current on any cpu
    always_comb
    begin
        slot_cur = 1'b0;
        for (int c = 0; c < CPU_COUNT; c++)
        begin
            if (cur_reg[c] == slot_reg)
            begin
                slot_cur = 1'b1;
            end
        end
    end

    // result word
    always_comb
    begin
        res = '0;
        res.out_cpu = cpu_raw_reg;
        if (!bad_cpu_reg)
        begin
            res.rescheduled   = resched_reg;
            res.current_task  = 6'(cur_sel);
            res.previous_task = 6'(prev_reg);
            res.recalculated  = recalc_reg;
            res.status        = status_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        cpu_raw_next = cpu_raw_reg;
        bad_cpu_next = bad_cpu_reg;
        slot_next    = slot_reg;
        prio_next    = prio_reg;
        ncnt_next    = ncnt_reg;
        idx_next     = idx_reg;
        v_next       = v_reg;
        aq_next      = aq_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        pick_next    = pick_reg;
        pass_next    = pass_reg;
        recalc_next  = recalc_reg;
        resched_next = resched_reg;
        status_next  = status_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        mem_we       = 1'b0;
        mem_waddr    = aq_reg;
        mem_wdata    = e;
        mem_raddr    = '0;
        rd_en        = 1'b0;
        res_valid    = 1'b0;

        unique case (state_reg)
            // write reset values over the whole table
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = '0;
                mem_wdata.prio = 8'd1;
                if (int'(idx_reg) < CPU_COUNT)
                begin
                    mem_wdata.present = 1'b1;
                    mem_wdata.st      = ST_RUNNING;
                end
                else
                begin
                    mem_wdata.st = ST_RUNNABLE;
                end
                if (idx_reg == IW'(TASK_SLOTS - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // take a request word
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.opcode;
                    cpu_raw_next = req.cpu;
                    slot_next    = in_slot;
                    prio_next    = req.new_priority;
                    ncnt_next    = req.new_counter;
                    resched_next = 1'b0;
                    recalc_next  = 1'b0;
                    status_next  = 1'b0;
                    bad_cpu_next = !(int'(req.cpu) < CPU_COUNT);
                    state_next   = S_DONE;
                    if (int'(req.cpu) < CPU_COUNT)
                    begin
                        prev_next = cur_reg[in_cpu_idx];
                        case (req.opcode) inside
                            OP_TICK, OP_YIELD, OP_EXIT, OP_PDIS, OP_PEN:
                            begin
                                mem_raddr  = cur_reg[in_cpu_idx];
                                rd_en      = 1'b1;
                                aq_next    = cur_reg[in_cpu_idx];
                                state_next = S_RMW;
                            end
                            OP_LOAD:
                            begin
                                if (int'(req.slot) < CPU_COUNT ||
                                    int'(req.slot) >= TASK_SLOTS)
                                begin
                                    status_next = 1'b1;
                                end
                                else
                                begin
                                    mem_raddr  = in_slot;
                                    rd_en      = 1'b1;
                                    aq_next    = in_slot;
                                    state_next = S_RMW;
                                end
                            end
                            default:
                            begin
                                state_next = S_DONE;
                            end
                        endcase
                    end
                end
            end

            // modify the addressed entry and write it back
            S_RMW:
            begin
                mem_we     = 1'b1;
                mem_waddr  = aq_reg;
                state_next = S_DONE;
                case (op_reg) inside
                    OP_TICK:
                    begin
                        if (dec <= 16'sd0 && e.preempt == 8'd0)
                        begin
                            mem_wdata.counter = 16'sd0;
                            resched_next      = 1'b1;
                            state_next        = S_SCAN;
                        end
                        else
                        begin
                            mem_wdata.counter = dec;
                        end
                    end
                    OP_YIELD, OP_EXIT:
                    begin
                        if (op_reg == OP_EXIT && int'(aq_reg) >= CPU_COUNT)
                        begin
                            mem_wdata.st = ST_ZOMBIE;
                        end
                        mem_wdata.counter = 16'sd0;
                        resched_next      = 1'b1;
                        state_next        = S_SCAN;
                    end
                    OP_PDIS:
                    begin
                        if (e.preempt != PREEMPT_MAX)
                        begin
                            mem_wdata.preempt = e.preempt + 8'd1;
                        end
                    end
                    OP_PEN:
                    begin
                        if (e.preempt != 8'd0)
                        begin
                            mem_wdata.preempt = e.preempt - 8'd1;
                        end
                    end
                    OP_LOAD:
                    begin
                        mem_wdata.present = 1'b1;
                        mem_wdata.prio    = prio_reg;
                        mem_wdata.counter = $signed({1'b0, ncnt_reg});
                        mem_wdata.preempt = 8'd0;
                        if (!slot_cur)
                        begin
                            mem_wdata.st = ST_RUNNABLE;
                        end
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
                idx_next   = IW'(CPU_COUNT);
                v_next     = 1'b0;
                found_next = 1'b0;
                pass_next  = '0;
            end

            // find the runnable task with the largest positive counter
            S_SCAN:
            begin
                if (v_reg && e.present && e.st == ST_RUNNABLE && e.counter > 16'sd0 &&
                    (!found_reg || e.counter > best_reg))
                begin
                    found_next = 1'b1;
                    best_next  = e.counter;
                    pick_next  = aq_reg;
                end
                if (idx_reg < IW'(TASK_SLOTS))
                begin
                    mem_raddr = idx_reg[AW-1:0];
                    rd_en     = 1'b1;
                    v_next    = 1'b1;
                    aq_next   = idx_reg[AW-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    v_next = 1'b0;
                    if (!v_reg)
                    begin
                        if (found_reg)
                        begin
                            state_next = S_PICK;
                        end
                        else
                        begin
                            idx_next   = IW'(CPU_COUNT);
                            state_next = S_RECALC;
                        end
                    end
                end
            end

            // recompute the counter of every present task from slot CPU_COUNT up
            S_RECALC:
            begin
                if (v_reg && e.present)
                begin
                    mem_we            = 1'b1;
                    mem_waddr         = aq_reg;
                    mem_wdata.counter = recalc_val;
                end
                if (idx_reg < IW'(TASK_SLOTS))
                begin
                    mem_raddr = idx_reg[AW-1:0];
                    rd_en     = 1'b1;
                    v_next    = 1'b1;
                    aq_next   = idx_reg[AW-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    v_next = 1'b0;
                    if (!v_reg)
                    begin
                        pick_next   = AW'(cpu_raw_reg);
                        recalc_next = 1'b1;
                        state_next  = S_PICK;
                    end
                end
            end

            // keep the current task, or fetch the pick
            S_PICK:
            begin
                if (pick_reg == cur_sel)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr  = pick_reg;
                    rd_en      = 1'b1;
                    state_next = S_PICK_CHK;
                end
            end

            // pick running elsewhere: zero it and rescan until the pass limit; else claim it
            S_PICK_CHK:
            begin
                mem_we    = 1'b1;
                mem_waddr = pick_reg;
                if (e.st == ST_RUNNING)
                begin
                    mem_wdata.counter = 16'sd0;
                    if (pass_reg == PW'(TASK_SLOTS))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pass_next  = pass_reg + 1'b1;
                        idx_next   = IW'(CPU_COUNT);
                        v_next     = 1'b0;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    mem_wdata.st = ST_RUNNING;
                    mem_raddr    = cur_sel;
                    rd_en        = 1'b1;
                    state_next   = S_PREV;
                end
            end

            // release the previous task
            S_PREV:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_sel;
                if (e.st != ST_ZOMBIE)
                begin
                    mem_wdata.st = ST_RUNNABLE;
                end
                cur_next[cpu_idx] = pick_reg;
                state_next        = S_DONE;
            end

            // hand the result word over
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            idx_reg     <= '0;
            v_reg       <= 1'b0;
            found_reg   <= 1'b0;
            pass_reg    <= '0;
            bad_cpu_reg <= 1'b0;
            for (int c = 0; c < CPU_COUNT; c++)
            begin
                cur_reg[c] <= AW'(c);
            end
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            v_reg       <= v_next;
            found_reg   <= found_next;
            pass_reg    <= pass_next;
            bad_cpu_reg <= bad_cpu_next;
            cur_reg     <= cur_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        cpu_raw_reg <= cpu_raw_next;
        slot_reg    <= slot_next;
        prio_reg    <= prio_next;
        ncnt_reg    <= ncnt_next;
        aq_reg      <= aq_next;
        best_reg    <= best_next;
        pick_reg    <= pick_next;
        recalc_reg  <= recalc_next;
        resched_reg <= resched_next;
        status_reg  <= status_next;
        prev_reg    <= prev_next;
    end

`ifndef SYNTHESIS
    // a read never meets a write to the same entry in one cycle
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en && mem_we |-> mem_raddr != mem_waddr)
        else $error("table read and write collide");

    // the clearing pass runs once after reset
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_CLEAR |=> state_reg != S_CLEAR)
        else $error("clearing pass re-entered");

    // a recompute only happens inside a scheduling decision
    a_recalc_resched: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.recalculated |-> res.rescheduled)
        else $error("recompute without reschedule");
`endif

endmodule

// File: hw/rtl/counter_priority_task_scheduler_core.sv
// counter_priority_task_scheduler_core: top level with result register
// depends on cpts_pkg, cpts_if, cpts_mem and cpts_ctrl
//
// Multi-cpu time-slice scheduler. After reset the task table is cleared in a
// pass during which no request word is taken. A request that schedules adds
// to its read-modify-write a scan of the table through its single read port,
// a second sweep when the counters of present tasks are recomputed, and a
// step to keep or switch the current task; each pick found running on another
// cpu repeats the scan, up to TASK_SLOTS+1 passes. One request is worked on at
// a time; the finished result word waits in an output register while the next
// request is taken.
module counter_priority_task_scheduler_core #(
    parameter int TASK_SLOTS = 64,
    parameter int CPU_COUNT = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    cpts_in_if.sink    req,
    cpts_out_if.source rsp
);
    import cpts_pkg::*;

    localparam int AW = $clog2(TASK_SLOTS);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;
    logic          res_valid;
    res_t          res;
    logic          out_free;
    logic          ov_reg;
    res_t          res_reg;

    cpts_ctrl #(
        .TASK_SLOTS (TASK_SLOTS),
        .CPU_COUNT  (CPU_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (out_free)
    );

    cpts_mem #(
        .DEPTH (TASK_SLOTS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register
    assign out_free = !ov_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (out_free)
        begin
            ov_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign rsp.valid         = ov_reg;
    assign rsp.out_cpu       = res_reg.out_cpu;
    assign rsp.rescheduled   = res_reg.rescheduled;
    assign rsp.current_task  = res_reg.current_task;
    assign rsp.previous_task = res_reg.previous_task;
    assign rsp.recalculated  = res_reg.recalculated;
    assign rsp.status        = res_reg.status;

endmodule

// File: sim/tb.sv
// tb: self-checking testbench of the counter priority task scheduler core
// depends on cpts_pkg, cpts_if and counter_priority_task_scheduler_core
module tb;
    import cpts_pkg::*;

    localparam int SLOTS = 64;
    localparam int CPUS = 4;
    localparam logic [2:0] OWNER_NONE = 3'd7;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int N_RANDOM = 400;

    logic clk;
    logic rst_n;

    cpts_in_if req ();
    cpts_out_if rsp ();

    counter_priority_task_scheduler_core #(
        .TASK_SLOTS(SLOTS),
        .CPU_COUNT(CPUS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // request word as stored in the stimulus table
    typedef struct {
        logic [2:0]  opcode;
        logic [1:0]  cpu;
        logic [5:0]  slot;
        logic [7:0]  new_priority;
        logic [14:0] new_counter;
        bit          has_fixed;
        res_t        fixed;
    } req_t;

    // scheduler mirror
    logic                sched_present [SLOTS];
    task_st_t            sched_st [SLOTS];
    logic signed [15:0]  sched_counter [SLOTS];
    logic [7:0]          sched_prio [SLOTS];
    logic [7:0]          sched_preempt [SLOTS];
    logic [2:0]          sched_owner [SLOTS];
    int                  sched_current [CPUS];

    res_t   expected_words[$];
    int     errors;
    int     idle_cycles;
    bit     hold_long;

    function automatic logic signed [15:0] sat16(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return CNT_MIN;
        return v[15:0];
    endfunction

    function automatic void mirror_reset();
        for (int i = 0; i < SLOTS; i++)
        begin
            sched_present[i] = (i < CPUS);
            sched_st[i] = (i < CPUS) ? ST_RUNNING : ST_RUNNABLE;
            sched_counter[i] = '0;
            sched_prio[i] = 8'd1;
            sched_preempt[i] = '0;
            sched_owner[i] = (i < CPUS) ? 3'(i) : OWNER_NONE;
        end
        for (int c = 0; c < CPUS; c++)
            sched_current[c] = c;
    endfunction

    // pick the next task for one cpu; returns 1 when counters were recomputed
    function automatic bit pick_next_task(int cpu);
        bit recalc;
        int best;
        int pick;
        int prev;
        int v;
        recalc = 0;
        for (int pass = 0; pass <= SLOTS; pass++)
        begin
            best = -1;
            pick = cpu;
            for (int i = CPUS; i < SLOTS; i++)
            begin
                v = sched_counter[i];
                if (sched_present[i] && sched_st[i] == ST_RUNNABLE && v > best && v > 0)
                begin
                    best = v;
                    pick = i;
                end
            end
            if (best == -1)
            begin
                for (int i = CPUS; i < SLOTS; i++)
                    if (sched_present[i])
                        sched_counter[i] = sat16(int'(sched_counter[i] >>> 1) +
                                                 int'(sched_prio[i]));
                recalc = 1;
                pick = cpu;
            end
            if (pick == sched_current[cpu])
                return recalc;
            if (sched_st[pick] == ST_RUNNING)
            begin
                sched_counter[pick] = '0;
                continue;
            end
            prev = sched_current[cpu];
            if (sched_st[prev] != ST_ZOMBIE)
                sched_st[prev] = ST_RUNNABLE;
            sched_owner[prev] = OWNER_NONE;
            sched_st[pick] = ST_RUNNING;
            sched_owner[pick] = 3'(cpu);
            sched_current[cpu] = pick;
            return recalc;
        end
        return recalc;
    endfunction

    // apply one request word to the mirror and return the result word
    function automatic res_t schedule_op(req_t r);
        res_t w;
        int cpu;
        int cur;
        bit is_cur;
        cpu = r.cpu;
        cur = sched_current[cpu];
        w = '0;
        w.out_cpu = r.cpu;
        w.previous_task = 6'(cur);
        case (r.opcode)
            OP_TICK:
            begin
                sched_counter[cur] = sat16(sched_counter[cur] - 1);
                if (sched_counter[cur] <= 0 && sched_preempt[cur] == 0)
                begin
                    sched_counter[cur] = '0;
                    w.recalculated = pick_next_task(cpu);
                    w.rescheduled = 1'b1;
                end
            end
            OP_YIELD, OP_EXIT:
            begin
                if (r.opcode == OP_EXIT && cur >= CPUS)
                    sched_st[cur] = ST_ZOMBIE;
                sched_counter[cur] = '0;
                w.recalculated = pick_next_task(cpu);
                w.rescheduled = 1'b1;
            end
            OP_PDIS:
                if (sched_preempt[cur] < PREEMPT_MAX)
                    sched_preempt[cur]++;
            OP_PEN:
                if (sched_preempt[cur] > 0)
                    sched_preempt[cur]--;
            OP_LOAD:
            begin
                if (r.slot < CPUS)
                    w.status = 1'b1;
                else
                begin
                    sched_present[r.slot] = 1'b1;
                    sched_prio[r.slot] = r.new_priority;
                    sched_counter[r.slot] = {1'b0, r.new_counter};
                    sched_preempt[r.slot] = '0;
                    is_cur = 0;
                    for (int c = 0; c < CPUS; c++)
                        if (sched_current[c] == r.slot)
                            is_cur = 1;
                    if (!is_cur)
                    begin
                        sched_st[r.slot] = ST_RUNNABLE;
                        sched_owner[r.slot] = OWNER_NONE;
                    end
                end
            end
            default:
            begin
            end
        endcase
        w.current_task = 6'(sched_current[cpu]);
        return w;
    endfunction

    function automatic req_t mk(logic [2:0] op, logic [1:0] cpu, logic [5:0] slot = 0,
                                logic [7:0] prio = 0, logic [14:0] cnt = 0);
        req_t r;
        r.opcode = op;
        r.cpu = cpu;
        r.slot = slot;
        r.new_priority = prio;
        r.new_counter = cnt;
        r.has_fixed = 0;
        r.fixed = '0;
        return r;
    endfunction

    function automatic req_t mk_fixed(req_t r, res_t w);
        r.has_fixed = 1;
        r.fixed = w;
        return r;
    endfunction

    function automatic req_t random_word();
        int k;
        k = $urandom_range(0, 99);
        if (k < 30)
            return mk(OP_LOAD, 2'($urandom), 6'($urandom_range(CPUS, SLOTS - 1)),
                      8'($urandom), ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                                 : 15'($urandom_range(0, 6)));
        if (k < 33)
            return mk(OP_LOAD, 2'($urandom), 6'($urandom_range(0, CPUS - 1)),
                      8'($urandom), 15'($urandom));
        if (k < 60)
            return mk(OP_TICK, 2'($urandom));
        if (k < 72)
            return mk(OP_YIELD, 2'($urandom));
        if (k < 82)
            return mk(OP_EXIT, 2'($urandom));
        if (k < 88)
            return mk(OP_PDIS, 2'($urandom));
        if (k < 95)
            return mk(OP_PEN, 2'($urandom));
        return mk(3'($urandom_range(6, 7)), 2'($urandom), 6'($urandom), 8'($urandom),
                  15'($urandom));
    endfunction

    // send one request word, honoring random gaps
    task automatic send_word(req_t r);
        res_t w;
        int gap;
        gap = $urandom_range(0, 19);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.opcode <= r.opcode;
        req.cpu <= r.cpu;
        req.slot <= r.slot;
        req.new_priority <= r.new_priority;
        req.new_counter <= r.new_counter;
        do
            @(posedge clk);
        while (!req.ready);
        w = schedule_op(r);
        if (r.has_fixed && w != r.fixed)
        begin
            $error("directed row differs from predictor: exp %h got %h", r.fixed, w);
            errors++;
        end
        expected_words.push_back(w);
    endtask

    // stop offering and wait until every result word is back
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // result side: random stalls, one long hold-off
    initial
    begin
        int n;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            rsp.ready <= 1'b1;
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                n = $urandom_range(0, 19);
                if (hold_long)
                begin
                    n = 3000;
                    hold_long = 0;
                end
                if (n != 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    // result word checker
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            res_t e;
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (rsp.out_cpu !== e.out_cpu)
                begin
                    $error("out_cpu exp %0d got %0d", e.out_cpu, rsp.out_cpu);
                    errors++;
                end
                if (rsp.rescheduled !== e.rescheduled)
                begin
                    $error("rescheduled exp %0d got %0d", e.rescheduled, rsp.rescheduled);
                    errors++;
                end
                if (rsp.current_task !== e.current_task)
                begin
                    $error("current_task exp %0d got %0d", e.current_task, rsp.current_task);
                    errors++;
                end
                if (rsp.previous_task !== e.previous_task)
                begin
                    $error("previous_task exp %0d got %0d", e.previous_task,
                           rsp.previous_task);
                    errors++;
                end
                if (rsp.recalculated !== e.recalculated)
                begin
                    $error("recalculated exp %0d got %0d", e.recalculated, rsp.recalculated);
                    errors++;
                end
                if (rsp.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, rsp.status);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        req_t table_rows[$];
        res_t fx;
        errors = 0;
        idle_cycles = 0;
        hold_long = 0;
        req.valid = 1'b0;
        req.opcode = '0;
        req.cpu = '0;
        req.slot = '0;
        req.new_priority = '0;
        req.new_counter = '0;
        rst_n = 1'b0;
        mirror_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows; fixed results only where obvious
        fx = '{out_cpu: 2'd0, rescheduled: 1'b1, current_task: 6'd0, previous_task: 6'd0,
               recalculated: 1'b1, status: 1'b0};
        table_rows.push_back(mk_fixed(mk(OP_TICK, 2'd0), fx));
        fx = '{out_cpu: 2'd3, rescheduled: 1'b0, current_task: 6'd3, previous_task: 6'd3,
               recalculated: 1'b0, status: 1'b1};
        table_rows.push_back(mk_fixed(mk(OP_LOAD, 2'd3, 6'd3, 8'hff, 15'h7fff), fx));
        fx = '{out_cpu: 2'd2, rescheduled: 1'b0, current_task: 6'd2, previous_task: 6'd2,
               recalculated: 1'b0, status: 1'b0};
        table_rows.push_back(mk_fixed(mk(3'd7, 2'd2, 6'h3f, 8'hff, 15'h7fff), fx));
        table_rows.push_back(mk(3'd6, 2'd1));
        table_rows.push_back(mk(OP_LOAD, 2'd0, 6'd63, 8'hff, 15'h7fff));
        table_rows.push_back(mk(OP_LOAD, 2'd1, 6'd4, 8'd0, 15'd0));
        table_rows.push_back(mk(OP_LOAD, 2'd2, 6'd10, 8'd5, 15'd5));
        table_rows.push_back(mk(OP_LOAD, 2'd3, 6'd11, 8'd5, 15'd5));
        table_rows.push_back(mk(OP_YIELD, 2'd0));
        table_rows.push_back(mk(OP_YIELD, 2'd1));
        table_rows.push_back(mk(OP_TICK, 2'd1));
        table_rows.push_back(mk(OP_PDIS, 2'd1));
        table_rows.push_back(mk(OP_TICK, 2'd1));
        table_rows.push_back(mk(OP_TICK, 2'd1));
        table_rows.push_back(mk(OP_PEN, 2'd1));
        table_rows.push_back(mk(OP_PEN, 2'd1));
        table_rows.push_back(mk(OP_TICK, 2'd1));
        table_rows.push_back(mk(OP_LOAD, 2'd2, 6'd63, 8'd1, 15'd3));
        table_rows.push_back(mk(OP_EXIT, 2'd0));
        table_rows.push_back(mk(OP_EXIT, 2'd2));
        table_rows.push_back(mk(OP_YIELD, 2'd3));
        table_rows.push_back(mk(OP_YIELD, 2'd3));
        table_rows.push_back(mk(OP_EXIT, 2'd3));
        foreach (table_rows[i])
            send_word(table_rows[i]);

        // sender pauses until everything is back
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_long = 1;
        for (int i = 0; i < 10; i++)
            send_word(random_word());

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 64 == 63)
                for (int j = 0; j < 4; j++)
                    send_word(mk(OP_PDIS, 2'(j)));
            send_word(random_word());
        end

        drain();
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
